/* rtl/ebr_pkg.sv */
package ebr_pkg;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_LD_RN = 5'd1, OP_LD_RR = 5'd2, OP_LD_RHL = 5'd3,
    OP_LD_ABC = 5'd4, OP_LD_ADE = 5'd5, OP_LD_ANN = 5'd6, OP_ST_HLR = 5'd7,
    OP_ST_HLN = 5'd8, OP_ADD = 5'd9, OP_ADC = 5'd10, OP_SUB = 5'd11,
    OP_SBC = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14, OP_XOR = 5'd15,
    OP_CP = 5'd16, OP_INC = 5'd17, OP_DEC = 5'd18, OP_SWAP = 5'd19,
    OP_DAA = 5'd20, OP_CPL = 5'd21, OP_CCF = 5'd22, OP_SCF = 5'd23,
    OP_RRC = 5'd24, OP_RLC = 5'd25, OP_RL = 5'd26, OP_RR = 5'd27
  } op_t;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;
  localparam logic [2:0] SRC_MEM = 3'd7;

  typedef struct packed {
    logic [4:0]  operation;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [7:0]  immediate;
    logic [15:0] direct_address;
    logic [7:0]  mem_data;
  } in_t;

  typedef struct packed {
    logic [7:0]  dest_value;
    logic [3:0]  flags_out;
    logic [15:0] mem_addr;
    logic        mem_write;
    logic [7:0]  mem_write_data;
  } out_t;

  // register-file operand bundle handed from the file to the ALU
  typedef struct packed {
    logic [7:0] a, b, c, d, e, h, l;
    logic [3:0] f;
  } regs_t;

  // write-back request from the ALU
  typedef struct packed {
    logic       we;
    logic [2:0] idx;
    logic [7:0] val;
    logic [3:0] f;
  } wb_t;

endpackage

/* rtl/ebr_regfile.sv */
module ebr_regfile (
  input  logic          clk,
  input  logic          rst,
  input  ebr_pkg::wb_t  wb,
  input  logic          wb_en,
  output ebr_pkg::regs_t regs
);

  // seven entries read at once: kept as registers with a shared write port
  logic [7:0] mem [7];
  logic [3:0] flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) mem[i] <= 8'd0;
      flags <= 4'd0;
    end else if (wb_en) begin
      if (wb.we && wb.idx != ebr_pkg::SRC_MEM) mem[wb.idx] <= wb.val;
      flags <= wb.f;
    end
  end

  assign regs = '{a: mem[0], b: mem[1], c: mem[2], d: mem[3], e: mem[4],
                  h: mem[5], l: mem[6], f: flags};

endmodule

/* rtl/ebr_alu.sv */
module ebr_alu (
  input  ebr_pkg::in_t   in,
  input  ebr_pkg::regs_t regs,
  output ebr_pkg::wb_t   wb,
  output ebr_pkg::out_t  res
);

  function automatic logic [7:0] rd(input ebr_pkg::regs_t r, input logic [2:0] i);
    unique case (i)
      ebr_pkg::REG_A: rd = r.a;
      ebr_pkg::REG_B: rd = r.b;
      ebr_pkg::REG_C: rd = r.c;
      ebr_pkg::REG_D: rd = r.d;
      ebr_pkg::REG_E: rd = r.e;
      ebr_pkg::REG_H: rd = r.h;
      ebr_pkg::REG_L: rd = r.l;
      default:        rd = 8'd0;
    endcase
  endfunction

  logic [7:0] a, src, v, r;
  logic [15:0] hl;
  logic cin;
  logic [8:0] sum;
  logic [4:0] hsum;
  logic [8:0] dr;

  always_comb begin
    a   = regs.a;
    hl  = {regs.h, regs.l};
    cin = regs.f[0];
    src = (in.src_reg == ebr_pkg::SRC_MEM) ? in.mem_data : rd(regs, in.src_reg);
    v   = rd(regs, in.dest_reg);
    wb  = '{we: 1'b0, idx: in.dest_reg, val: 8'd0, f: regs.f};
    res = '0;
    r = 8'd0; sum = 9'd0; hsum = 5'd0; dr = 9'd0;
    unique case (in.operation)
      ebr_pkg::OP_LD_RN: begin wb.we = 1'b1; wb.val = in.immediate; end
      ebr_pkg::OP_LD_RR: begin
        if (in.src_reg == ebr_pkg::SRC_MEM) res.mem_addr = hl;
        wb.we = 1'b1; wb.val = src;
      end
      ebr_pkg::OP_LD_RHL: begin
        res.mem_addr = hl; wb.we = 1'b1; wb.val = in.mem_data;
      end
      ebr_pkg::OP_LD_ABC, ebr_pkg::OP_LD_ADE, ebr_pkg::OP_LD_ANN: begin
        unique case (in.operation)
          ebr_pkg::OP_LD_ABC: res.mem_addr = {regs.b, regs.c};
          ebr_pkg::OP_LD_ADE: res.mem_addr = {regs.d, regs.e};
          default:            res.mem_addr = in.direct_address;
        endcase
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A; wb.val = in.mem_data;
      end
      ebr_pkg::OP_ST_HLR: begin
        res.mem_addr = hl; res.mem_write = 1'b1; res.mem_write_data = src;
      end
      ebr_pkg::OP_ST_HLN: begin
        res.mem_addr = hl; res.mem_write = 1'b1; res.mem_write_data = in.immediate;
      end
      ebr_pkg::OP_ADD, ebr_pkg::OP_ADC: begin
        if (in.src_reg == ebr_pkg::SRC_MEM) res.mem_addr = hl;
        sum  = {1'b0, a} + {1'b0, src}
             + {8'd0, cin & (in.operation == ebr_pkg::OP_ADC)};
        hsum = {1'b0, a[3:0]} + {1'b0, src[3:0]}
             + {4'd0, cin & (in.operation == ebr_pkg::OP_ADC)};
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A; wb.val = sum[7:0];
        wb.f = {sum[7:0] == 8'd0, 1'b0, hsum[4], sum[8]};
      end
      ebr_pkg::OP_SUB, ebr_pkg::OP_SBC, ebr_pkg::OP_CP: begin
        if (in.src_reg == ebr_pkg::SRC_MEM) res.mem_addr = hl;
        sum  = {1'b0, a} - {1'b0, src}
             - {8'd0, cin & (in.operation == ebr_pkg::OP_SBC)};
        hsum = {1'b0, a[3:0]} - {1'b0, src[3:0]}
             - {4'd0, cin & (in.operation == ebr_pkg::OP_SBC)};
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A;
        wb.val = (in.operation == ebr_pkg::OP_CP) ? a : sum[7:0];
        wb.f = {sum[7:0] == 8'd0, 1'b1, hsum[4], sum[8]};
      end
      ebr_pkg::OP_AND, ebr_pkg::OP_OR, ebr_pkg::OP_XOR: begin
        if (in.src_reg == ebr_pkg::SRC_MEM) res.mem_addr = hl;
        unique case (in.operation)
          ebr_pkg::OP_AND: r = a & src;
          ebr_pkg::OP_OR:  r = a | src;
          default:         r = a ^ src;
        endcase
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A; wb.val = r;
        wb.f = {r == 8'd0, 1'b0, in.operation == ebr_pkg::OP_AND, 1'b0};
      end
      ebr_pkg::OP_INC: begin
        r = v + 8'd1; wb.we = 1'b1; wb.val = r;
        wb.f = {r == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
      end
      ebr_pkg::OP_DEC: begin
        r = v - 8'd1; wb.we = 1'b1; wb.val = r;
        wb.f = {r == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
      end
      ebr_pkg::OP_SWAP: begin
        r = {v[3:0], v[7:4]}; wb.we = 1'b1; wb.val = r; wb.f = {r == 8'd0, 3'b000};
      end
      ebr_pkg::OP_DAA: begin
        dr = {1'b0, a};
        wb.f[0] = cin;
        if (!regs.f[2]) begin
          if (cin || a > 8'h99) begin dr = dr + 9'h060; wb.f[0] = 1'b1; end
          if (regs.f[1] || dr[3:0] > 4'd9) dr = dr + 9'h006;
        end else begin
          if (cin) dr = dr - 9'h060;
          if (regs.f[1]) dr = dr - 9'h006;
        end
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A; wb.val = dr[7:0];
        wb.f[3] = dr[7:0] == 8'd0; wb.f[2] = regs.f[2]; wb.f[1] = 1'b0;
      end
      ebr_pkg::OP_CPL: begin
        wb.we = 1'b1; wb.idx = ebr_pkg::REG_A; wb.val = ~a;
        wb.f = {regs.f[3], 2'b11, regs.f[0]};
      end
      ebr_pkg::OP_CCF: wb.f = {regs.f[3], 2'b00, ~cin};
      ebr_pkg::OP_SCF: wb.f = {regs.f[3], 2'b00, 1'b1};
      ebr_pkg::OP_RRC, ebr_pkg::OP_RLC, ebr_pkg::OP_RL, ebr_pkg::OP_RR: begin
        unique case (in.operation)
          ebr_pkg::OP_RRC: begin r = {v[0], v[7:1]}; wb.f[0] = v[0]; end
          ebr_pkg::OP_RLC: begin r = {v[6:0], v[7]}; wb.f[0] = v[7]; end
          ebr_pkg::OP_RL:  begin r = {v[6:0], cin};  wb.f[0] = v[7]; end
          default:         begin r = {cin, v[7:1]};  wb.f[0] = v[0]; end
        endcase
        wb.we = 1'b1; wb.val = r; wb.f[3:1] = {r == 8'd0, 2'b00};
      end
      default: ;
    endcase
    res.dest_value = wb.we ? wb.val : 8'd0;
    res.flags_out  = wb.f;
  end

endmodule

/* rtl/eight_bit_register_alu_execute.sv */
// Execute stage: one decoded instruction per beat, result registered into the output.
// Throughput 1 beat/cycle while the output is not stalled.
// Register file and flags are updated at acceptance, so the next beat
// sees them at once with no bubble. The output register holds a result
// while stalled; a new beat is taken whenever the output is free or drains.
// Reset (rst, synchronous) zeroes registers and flags and empties output.
module eight_bit_register_alu_execute (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ebr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ebr_pkg::out_t out_data
);

  ebr_pkg::regs_t regs;
  ebr_pkg::wb_t   wb;
  ebr_pkg::out_t  res;
  logic           take;

  // stall only while a held result cannot drain this cycle
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  ebr_regfile u_rf (.clk(clk), .rst(rst), .wb(wb), .wb_en(take), .regs(regs));
  ebr_alu     u_alu (.in(in_data), .regs(regs), .wb(wb), .res(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload register: load on every accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (take) out_data <= res;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted beat produced no result");
  a_nowr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.mem_write |-> out_data.mem_write_data == 8'd0)
    else $error("store data without store");

endmodule
